[hdl/fcbd_pkg.sv]
`timescale 1ns / 1ps
// fcbd_pkg: shared types and constant tables for the FSK correlator-bank demodulator.
// Holds the sequencer state type, register indexes, CORDIC angle table and template ROM.
package fcbd_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_MIX,
    S_CORR,
    S_MAG,
    S_EMIT
  } state_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SPS   = 2'd0;
  localparam logic [1:0] CFG_STEP  = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  localparam logic [6:0]  SPS_RESET   = 7'd4;
  localparam logic [6:0]  SPS_MAX     = 7'd64;
  localparam logic [15:0] LIMIT_RESET = 16'd800;

  // NCO / CORDIC
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_KW    = 5;
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  // template ROM, units of 1/10000
  localparam int ROM_DEPTH = 128;
  localparam int ROM_AW    = 7;

  localparam logic signed [15:0] TAP_I [ROM_DEPTH] = '{
    -6704, -9497, -9921, -7853, -3461,  1951,  6788,  9625,
     9625,  6788,  1951, -3461, -7853, -9921, -9497, -6704,
    -6704, -9497, -9921, -7853, -3461,  1951,  6788,  9625,
     9625,  6899,  6899,  9625,  9625,  6844,  4425,  3082,
     3082,  4425,  6844,  9625,  9625,  6899,  6899,  9625,
     9625,  6899,  6899,  9625,  9625,  6844,  4425,  3082,
     3082,  4425,  6844,  9625,  9625,  6899,  6899,  9625,
     9625,  6788,  1951, -3461, -7853, -9921, -9497, -6704,
     3082,  4425,  6844,  9625,  9625,  6899,  6899,  9625,
     9625,  6788,  1951, -3461, -7853, -9921, -9497, -6704,
     3082,  4425,  6844,  9625,  9625,  6899,  6899,  9625,
     9625,  6899,  6899,  9625,  9625,  6844,  4425,  3082,
    -6704, -9497, -9921, -7853, -3461,  1951,  6788,  9625,
     9625,  6899,  6899,  9625,  9625,  6844,  4425,  3082,
    -6704, -9497, -9921, -7853, -3461,  1951,  6788,  9625,
     9625,  6788,  1951, -3461, -7853, -9921, -9497, -6704
  };

  localparam logic signed [15:0] TAP_Q [ROM_DEPTH] = '{
    -1062, -1430,  1251,  6191,  9382,  9808,  7343,  2714,
    -2714, -7343, -9808, -9382, -6191, -1251,  1430,  1062,
    -1062, -1430,  1251,  6191,  9382,  9808,  7343,  2714,
    -2714, -7239, -7239, -2714,  2714,  7291,  8523,  6048,
     6048,  8523,  7291,  2714, -2714, -7239, -7239, -2714,
     2714,  7239,  7239,  2714, -2714, -7291, -8523, -6048,
     6048,  8523,  7291,  2714, -2714, -7239, -7239, -2714,
     2714,  7343,  9808,  9382,  6191,  1251, -1430, -1062,
    -6048, -8523, -7291, -2714,  2714,  7239,  7239,  2714,
    -2714, -7343, -9808, -9382, -6191, -1251,  1430,  1062,
    -6048, -8523, -7291, -2714,  2714,  7239,  7239,  2714,
    -2714, -7239, -7239, -2714,  2714,  7291,  8523,  6048,
     1062,  1430, -1251, -6191, -9382, -9808, -7343, -2714,
     2714,  7239,  7239,  2714, -2714, -7291, -8523, -6048,
     1062,  1430, -1251, -6191, -9382, -9808, -7343, -2714,
     2714,  7343,  9808,  9382,  6191,  1251, -1430, -1062
  };

endpackage

[hdl/fsk_correlator_bank_demod_top.sv]
`timescale 1ns / 1ps
// fsk_correlator_bank_demod_top: noncoherent FSK demodulator built around one shared multiplier.
// Depends on fcbd_pkg for the state type, register indexes, CORDIC table and template ROM.
//
// Each sample item is mixed by an NCO (iterative CORDIC, then the mixing products through the
// shared multiplier) and shifted into the sample window. On a symbol boundary the window is
// correlated against every template, one real product per cycle through the same multiplier.
// The input is not ready while an item is in work, and a result waits in the output register
// while the next item is taken. No clearing pass.
module fsk_correlator_bank_demod_top
  import fcbd_pkg::*;
#(
  parameter int TAPS_PER_CORRELATOR = 16,
  parameter int NUM_CORRELATORS     = 8,
  parameter int SAMPLE_BITS         = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] sample_i, [31:16] sample_q
  input  logic        in_tuser,   // [0] kind (1 = restart burst)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] bit_res, [3:1] winner, [7:4] zero
  output logic        out_tuser,  // [0] burst_start
  output logic        out_tlast,  // last bit of the burst
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int TW     = $clog2(TAPS_PER_CORRELATOR);
  localparam int CW     = $clog2(NUM_CORRELATORS);
  localparam int CORR_W = SAMPLE_BITS + 16 + TW;
  localparam int ACC_W  = (CORR_W > 34) ? CORR_W : 34;
  localparam int SHIFT  = SAMPLE_BITS - 8;
  localparam int MAG_W  = CORR_W - SHIFT;
  localparam int MUL_W  = MAG_W + 1;
  localparam int SQ_W   = 2 * MAG_W + 1;

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(16384);

  // round half up by 2^15 and saturate to a window entry
  function automatic logic signed [SAMPLE_BITS-1:0] mix_round(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = (v + RND) >>> 15;
    if (r > SMAX) r = SMAX;
    else if (r < SMIN) r = SMIN;
    return r[SAMPLE_BITS-1:0];
  endfunction

  // configuration
  logic [6:0]  sps_r;
  logic [31:0] phase_step_r;
  logic [15:0] limit_r;

  // control state
  state_t state_r, state_nxt;
  logic   running_r, running_nxt;
  logic [5:0]  sp_r, sp_nxt;
  logic [15:0] bc_r, bc_nxt;
  logic [31:0] nco_r, nco_nxt;

  // datapath registers
  logic signed [15:0] si_r, si_nxt, sq_r, sq_nxt;
  logic signed [32:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic               flip_r, flip_nxt;
  logic [CORDIC_KW-1:0] k_r, k_nxt;
  logic [1:0]         step_r, step_nxt;
  logic signed [ACC_W-1:0] re_r, re_nxt, im_r, im_nxt;
  logic signed [SAMPLE_BITS-1:0] wi_r, wi_nxt;
  logic signed [SAMPLE_BITS-1:0] win_i_r [TAPS_PER_CORRELATOR];
  logic signed [SAMPLE_BITS-1:0] win_q_r [TAPS_PER_CORRELATOR];
  logic signed [SAMPLE_BITS-1:0] win_i_nxt [TAPS_PER_CORRELATOR];
  logic signed [SAMPLE_BITS-1:0] win_q_nxt [TAPS_PER_CORRELATOR];
  logic [TW-1:0]     tap_r, tap_nxt;
  logic [CW-1:0]     corr_r, corr_nxt;
  logic [ROM_AW-1:0] rom_r, rom_nxt;
  logic [SQ_W-1:0]   msq_r, msq_nxt, best_r, best_nxt;
  logic [CW-1:0]     widx_r, widx_nxt;

  // pending result and output register
  logic       pbit_r, pbit_nxt, pstart_r, pstart_nxt, plast_r, plast_nxt;
  logic [2:0] pwin_r, pwin_nxt;
  logic       ovalid_r, ovalid_nxt, obit_r, obit_nxt, ostart_r, ostart_nxt, olast_r, olast_nxt;
  logic [2:0] owin_r, owin_nxt;

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_acc;
  logic [2*MAG_W-1:0]        prod_sq;

  // misc combinational
  logic               in_fire;
  logic [31:0]        ph_new, ph_quad, ph_turn;
  logic signed [32:0] dx, dy, xr, yr;
  logic signed [15:0] cos_v, sin_v;
  logic signed [ACC_W-1:0] mag_src;
  logic [ACC_W-1:0]   mag_abs, mag_shr;
  logic [MAG_W-1:0]   mag_op;
  logic [6:0]         sps_eff, sp_inc;
  logic [15:0]        lim_eff, bc_inc;
  logic [SQ_W-1:0]    tot;
  logic [CW-1:0]      w_final;
  logic signed [15:0] tap_i, tap_q;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'b0000, owin_r, obit_r};
  assign out_tuser  = ostart_r;
  assign out_tlast  = olast_r;

  // NCO output: round, clamp and undo the half-turn fold
  always_comb begin
    xr = (x_r + 33'sd16384) >>> 15;
    yr = (y_r + 33'sd16384) >>> 15;
    if (xr > 33'sd32767) xr = 33'sd32767;
    else if (xr < -33'sd32767) xr = -33'sd32767;
    if (yr > 33'sd32767) yr = 33'sd32767;
    else if (yr < -33'sd32767) yr = -33'sd32767;
    cos_v = flip_r ? -xr[15:0] : xr[15:0];
    sin_v = flip_r ? -yr[15:0] : yr[15:0];
  end

  // magnitude operand for squaring
  always_comb begin
    mag_src = step_r[0] ? im_r : re_r;
    mag_abs = mag_src[ACC_W-1] ? unsigned'(-mag_src) : unsigned'(mag_src);
    mag_shr = mag_abs >> SHIFT;
    mag_op  = mag_shr[MAG_W-1:0];
  end

  assign tap_i = TAP_I[rom_r];
  assign tap_q = TAP_Q[rom_r];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MIX: begin
        mul_a = step_r[0] ? MUL_W'(sq_r) : MUL_W'(si_r);
        mul_b = (step_r == 2'd0 || step_r == 2'd3) ? MUL_W'(cos_v) : MUL_W'(sin_v);
      end
      S_CORR: begin
        mul_a = step_r[0] ? MUL_W'(win_q_r[0]) : MUL_W'(win_i_r[0]);
        mul_b = (step_r == 2'd0 || step_r == 2'd3) ? MUL_W'(tap_i) : MUL_W'(tap_q);
      end
      S_MAG: begin
        mul_a = signed'({1'b0, mag_op});
        mul_b = signed'({1'b0, mag_op});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_acc = prod[ACC_W-1:0];
  assign prod_sq  = prod[2*MAG_W-1:0];

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt   = state_r;
    running_nxt = running_r;
    sp_nxt      = sp_r;
    bc_nxt      = bc_r;
    nco_nxt     = nco_r;
    si_nxt      = si_r;
    sq_nxt      = sq_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    z_nxt       = z_r;
    flip_nxt    = flip_r;
    k_nxt       = k_r;
    step_nxt    = step_r;
    re_nxt      = re_r;
    im_nxt      = im_r;
    wi_nxt      = wi_r;
    win_i_nxt   = win_i_r;
    win_q_nxt   = win_q_r;
    tap_nxt     = tap_r;
    corr_nxt    = corr_r;
    rom_nxt     = rom_r;
    msq_nxt     = msq_r;
    best_nxt    = best_r;
    widx_nxt    = widx_r;
    pbit_nxt    = pbit_r;
    pstart_nxt  = pstart_r;
    plast_nxt   = plast_r;
    pwin_nxt    = pwin_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    obit_nxt    = obit_r;
    ostart_nxt  = ostart_r;
    olast_nxt   = olast_r;
    owin_nxt    = owin_r;
    ph_new      = nco_r + phase_step_r;
    ph_quad     = ph_new + 32'h4000_0000;
    ph_turn     = ph_quad[31] ? ph_new + 32'h8000_0000 : ph_new;
    dx          = y_r >>> k_r;
    dy          = x_r >>> k_r;
    sps_eff     = (sps_r == 7'd0) ? 7'd1 : ((sps_r > SPS_MAX) ? SPS_MAX : sps_r);
    sp_inc      = {1'b0, sp_r} + 7'd1;
    lim_eff     = (limit_r == 16'd0) ? 16'd1 : limit_r;
    bc_inc      = bc_r + 16'd1;
    tot         = msq_r + SQ_W'(prod_sq);
    w_final     = (tot > best_r) ? corr_r : widx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser) begin
            // restart: arm burst, queue start marker
            running_nxt = 1'b1;
            sp_nxt      = '0;
            nco_nxt     = '0;
            bc_nxt      = '0;
            pbit_nxt    = 1'b0;
            pstart_nxt  = 1'b1;
            plast_nxt   = 1'b0;
            pwin_nxt    = '0;
            state_nxt   = S_EMIT;
          end else if (running_r) begin
            // advance NCO, load CORDIC
            nco_nxt   = ph_new;
            si_nxt    = signed'(in_tdata[15:0]);
            sq_nxt    = signed'(in_tdata[31:16]);
            flip_nxt  = ph_quad[31];
            z_nxt     = 34'(signed'(ph_turn));
            x_nxt     = CORDIC_X0;
            y_nxt     = '0;
            k_nxt     = '0;
            state_nxt = S_CORDIC;
          end
        end
      end
      S_CORDIC: begin
        // one rotation per cycle
        if (!z_r[33]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - signed'({2'b00, ATAN_TURNS[k_r]});
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + signed'({2'b00, ATAN_TURNS[k_r]});
        end
        k_nxt = k_r + 1'b1;
        if (k_r == CORDIC_KW'(CORDIC_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        // i*c - q*s, then i*s + q*c
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: re_nxt = prod_acc;
          2'd1: wi_nxt = mix_round(re_r - prod_acc);
          2'd2: re_nxt = prod_acc;
          default: begin
            for (int t = 0; t < TAPS_PER_CORRELATOR - 1; t++) begin
              win_i_nxt[t] = win_i_r[t+1];
              win_q_nxt[t] = win_q_r[t+1];
            end
            win_i_nxt[TAPS_PER_CORRELATOR-1] = wi_r;
            win_q_nxt[TAPS_PER_CORRELATOR-1] = mix_round(re_r + prod_acc);
            if (sp_inc >= sps_eff) begin
              sp_nxt    = '0;
              re_nxt    = '0;
              im_nxt    = '0;
              tap_nxt   = '0;
              corr_nxt  = '0;
              rom_nxt   = '0;
              best_nxt  = '0;
              widx_nxt  = '0;
              state_nxt = S_CORR;
            end else begin
              sp_nxt    = sp_inc[5:0];
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_CORR: begin
        // one real product per cycle; rotate window after each tap
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: re_nxt = re_r + prod_acc;
          2'd1: re_nxt = re_r - prod_acc;
          2'd2: im_nxt = im_r + prod_acc;
          default: begin
            im_nxt = im_r + prod_acc;
            for (int t = 0; t < TAPS_PER_CORRELATOR - 1; t++) begin
              win_i_nxt[t] = win_i_r[t+1];
              win_q_nxt[t] = win_q_r[t+1];
            end
            win_i_nxt[TAPS_PER_CORRELATOR-1] = win_i_r[0];
            win_q_nxt[TAPS_PER_CORRELATOR-1] = win_q_r[0];
            rom_nxt = rom_r + 1'b1;
            tap_nxt = tap_r + 1'b1;
            if (tap_r == TW'(TAPS_PER_CORRELATOR - 1)) begin
              step_nxt  = '0;
              state_nxt = S_MAG;
            end
          end
        endcase
      end
      S_MAG: begin
        // square both parts, keep the first largest
        if (!step_r[0]) begin
          msq_nxt  = SQ_W'(prod_sq);
          step_nxt = 2'd1;
        end else begin
          step_nxt = '0;
          if (tot > best_r) begin
            best_nxt = tot;
            widx_nxt = corr_r;
          end
          if (corr_r == CW'(NUM_CORRELATORS - 1)) begin
            bc_nxt     = bc_inc;
            pwin_nxt   = 3'(w_final);
            pbit_nxt   = !pwin_nxt[1];
            pstart_nxt = 1'b0;
            plast_nxt  = (bc_inc >= lim_eff);
            if (bc_inc >= lim_eff) running_nxt = 1'b0;
            state_nxt  = S_EMIT;
          end else begin
            corr_nxt  = corr_r + 1'b1;
            re_nxt    = '0;
            im_nxt    = '0;
            tap_nxt   = '0;
            state_nxt = S_CORR;
          end
        end
      end
      S_EMIT: begin
        // hold until output register is free
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          obit_nxt   = pbit_r;
          ostart_nxt = pstart_r;
          olast_nxt  = plast_r;
          owin_nxt   = pwin_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      running_r <= 1'b0;
      sp_r      <= '0;
      bc_r      <= '0;
      nco_r     <= '0;
      ovalid_r  <= 1'b0;
      sps_r        <= SPS_RESET;
      phase_step_r <= '0;
      limit_r      <= LIMIT_RESET;
      for (int t = 0; t < TAPS_PER_CORRELATOR; t++) begin
        win_i_r[t] <= '0;
        win_q_r[t] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      running_r <= running_nxt;
      sp_r      <= sp_nxt;
      bc_r      <= bc_nxt;
      nco_r     <= nco_nxt;
      ovalid_r  <= ovalid_nxt;
      win_i_r   <= win_i_nxt;
      win_q_r   <= win_q_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SPS:   sps_r        <= cfg_wdata[6:0];
          CFG_STEP:  phase_step_r <= cfg_wdata;
          CFG_LIMIT: limit_r      <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    sq_r   <= sq_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
    k_r    <= k_nxt;
    step_r <= step_nxt;
    re_r   <= re_nxt;
    im_r   <= im_nxt;
    wi_r   <= wi_nxt;
    tap_r  <= tap_nxt;
    corr_r <= corr_nxt;
    rom_r  <= rom_nxt;
    msq_r  <= msq_nxt;
    best_r <= best_nxt;
    widx_r <= widx_nxt;
    pbit_r   <= pbit_nxt;
    pstart_r <= pstart_nxt;
    plast_r  <= plast_nxt;
    pwin_r   <= pwin_nxt;
    obit_r   <= obit_nxt;
    ostart_r <= ostart_nxt;
    olast_r  <= olast_nxt;
    owin_r   <= owin_nxt;
  end

  // restart clears burst counters and arms the block
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser |=> running_r && bc_r == 16'd0 && nco_r == 32'd0 && state_r == S_EMIT)
    else $error("restart did not arm burst");

  // samples while idle change nothing
  a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tuser && !running_r |=> state_r == S_IDLE && $stable(nco_r))
    else $error("sample taken while burst idle");

  // correlation only starts on a symbol boundary
  a_corr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CORR || state_r == S_MAG |-> sp_r == 6'd0)
    else $error("correlation off symbol boundary");

  // a result with last set ends the burst
  a_last_stop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && plast_r |-> !running_r)
    else $error("burst still running after last bit");

endmodule
